// ===== rtl/xrts_pkg.sv =====
// Shared types, codes and helpers for the XML root tag scanner.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package xrts_pkg;

  localparam int MAX_NAME_BYTES_DEF = 16;
  localparam int TAG_BYTES = 16;
  localparam int LEN_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAG_LOW    = 2'd0,
    CFG_TAG_HIGH   = 2'd1,
    CFG_TAG_LENGTH = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OPEN_PI   = 3'd1,
    ST_OPEN_CMT  = 3'd2,
    ST_DECL      = 3'd3,
    ST_NO_ROOT   = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_MISMATCH  = 3'd6,
    ST_TOO_LONG  = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    PH_WS        = 4'd0,
    PH_LT        = 4'd1,
    PH_BANG      = 4'd2,
    PH_BANG_DASH = 4'd3,
    PH_PI        = 4'd4,
    PH_COMMENT   = 4'd5,
    PH_NAME      = 4'd6,
    PH_DONE      = 4'd7,
    PH_NOROOT    = 4'd8,
    PH_DECL      = 4'd9,
    PH_EMPTY     = 4'd10
  } phase_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [LEN_W-1:0] name_length;
    logic [63:0]      name_low;
    logic [63:0]      name_high;
    logic             tag_learned;
  } result_t;

  // Name byte write from the scanner toward the learned-tag memory.
  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [7:0] value;
  } tag_wr_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] length;
  } tag_commit_t;

  // Effective tag as seen by the scanner: length and the byte at the lookup index.
  typedef struct packed {
    logic [LEN_W-1:0] eff_len;
    logic [7:0]       ref_byte;
  } tag_view_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
  endfunction

  function automatic logic is_term(input logic [7:0] b);
    return is_ws(b) || (b == CH_SLASH) || (b == CH_GT) || (b == CH_EQ);
  endfunction

endpackage

// ===== rtl/xrts_if.sv =====
// Valid/ready channel interfaces: input bytes, results and register writes.
// Depends on xrts_pkg for field widths.
`timescale 1ns / 1ps

interface xrts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       first_of_file;
  logic       last_of_file;

  modport source(output valid, data_byte, has_byte, first_of_file, last_of_file,
                 input ready);
  modport sink(input valid, data_byte, has_byte, first_of_file, last_of_file,
               output ready);
endinterface

interface xrts_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [xrts_pkg::LEN_W-1:0] name_length;
  logic [63:0]               name_low;
  logic [63:0]               name_high;
  logic                      tag_learned;

  modport source(output valid, status, name_length, name_low, name_high, tag_learned,
                 input ready);
  modport sink(input valid, status, name_length, name_low, name_high, tag_learned,
               output ready);
endinterface

interface xrts_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [xrts_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/xrts_tag_store.sv =====
// Tag store: configuration registers and the learned-tag memory (sync read).
// Depends on xrts_pkg and xrts_cfg_if.
`timescale 1ns / 1ps

module xrts_tag_store (
  input  logic                  clk,
  input  logic                  rst,
  xrts_cfg_if.sink              cfg,
  input  xrts_pkg::tag_wr_t     wr,
  input  xrts_pkg::tag_commit_t commit,
  input  logic [3:0]            raddr,
  input  logic [3:0]            sel,
  output xrts_pkg::tag_view_t   view
);

  logic [63:0]                exp_low;
  logic [63:0]                exp_high;
  logic [xrts_pkg::LEN_W-1:0] exp_len;
  logic [xrts_pkg::LEN_W-1:0] learned_length;

  logic [7:0] learned_mem [xrts_pkg::TAG_BYTES];
  logic [7:0] mem_q;
  logic [7:0] first_byte;

  logic [127:0]               exp_tag;
  logic [xrts_pkg::LEN_W-1:0] exp_len_clip;
  logic                       mem_we;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_low  <= '0;
      exp_high <= '0;
      exp_len  <= '0;
    end else if (cfg.valid) begin
      unique case (xrts_pkg::cfg_reg_t'(cfg.index))
        xrts_pkg::CFG_TAG_LOW:    exp_low  <= cfg.data;
        xrts_pkg::CFG_TAG_HIGH:   exp_high <= cfg.data;
        xrts_pkg::CFG_TAG_LENGTH: exp_len  <= cfg.data[xrts_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learned_length <= '0;
    end else if (commit.en) begin
      learned_length <= commit.length;
    end
  end

  // Fill the memory only until a tag is learned; after that it is read-only,
  // so a read never overlaps a write that matters. Byte zero is also held in
  // a register because a restart drops the index to zero with no time to read.
  assign mem_we = wr.en && (learned_length == '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      learned_mem[wr.addr] <= wr.value;
      if (wr.addr == 4'd0) begin
        first_byte <= wr.value;
      end
    end
    mem_q <= learned_mem[raddr];
  end

  assign exp_tag = {exp_high, exp_low};
  assign exp_len_clip = (exp_len > xrts_pkg::LEN_W'(xrts_pkg::TAG_BYTES)) ?
                        xrts_pkg::LEN_W'(xrts_pkg::TAG_BYTES) : exp_len;

  always_comb begin
    if (exp_len != '0) begin
      view.eff_len  = exp_len_clip;
      view.ref_byte = exp_tag[{sel, 3'b000} +: 8];
    end else begin
      view.eff_len  = learned_length;
      view.ref_byte = (sel == 4'd0) ? first_byte : mem_q;
    end
  end

endmodule

// ===== rtl/xrts_scan_core.sv =====
// Scan core: prolog state machine, name capture and per-byte tag compare.
// Depends on xrts_pkg; talks to xrts_tag_store through package structs.
`timescale 1ns / 1ps

module xrts_scan_core #(
  parameter int MAX_NAME_BYTES = xrts_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  logic [7:0]            data_byte,
  input  logic                  has_byte,
  input  logic                  first_of_file,
  input  logic                  last_of_file,
  input  xrts_pkg::tag_view_t   view,
  output xrts_pkg::tag_wr_t     wr,
  output xrts_pkg::tag_commit_t commit,
  output logic [3:0]            raddr,
  output logic [3:0]            sel,
  output logic                  res_valid,
  output xrts_pkg::result_t     res
);

  localparam int NameCap = (MAX_NAME_BYTES < xrts_pkg::TAG_BYTES) ?
                           MAX_NAME_BYTES : xrts_pkg::TAG_BYTES;
  localparam int IdxW = (NameCap > 1) ? $clog2(NameCap) : 1;
  localparam int LW = xrts_pkg::LEN_W;

  xrts_pkg::phase_t phase;
  logic [1:0]       cp;
  logic [LW-1:0]    cap_len;
  logic             differs;
  logic [7:0]       cap_name [NameCap];

  xrts_pkg::phase_t ph_base, ph_scan;
  logic [1:0]       cp_base, cp_scan;
  logic [LW-1:0]    len_base, len_scan, len_d, n_rep;
  logic             diff_base, diff_scan, take, learn, show_name;
  logic [7:0]       bytes_out [xrts_pkg::TAG_BYTES];
  xrts_pkg::status_t res_status;
  logic             res_learned;
  logic [63:0]      name_lo;
  logic [63:0]      name_hi;

  // Next phase and closer progress.
  always_comb begin
    ph_base = first_of_file ? xrts_pkg::PH_WS : phase;
    cp_base = first_of_file ? 2'd0 : cp;
    ph_scan = ph_base;
    cp_scan = cp_base;
    take    = 1'b0;
    if (has_byte) begin
      unique case (ph_base)
        xrts_pkg::PH_WS: begin
          if (data_byte == xrts_pkg::CH_LT) ph_scan = xrts_pkg::PH_LT;
          else if (!xrts_pkg::is_ws(data_byte)) ph_scan = xrts_pkg::PH_NOROOT;
        end
        xrts_pkg::PH_LT: begin
          if (data_byte == xrts_pkg::CH_QUEST) begin
            ph_scan = xrts_pkg::PH_PI;
            cp_scan = 2'd0;
          end else if (data_byte == xrts_pkg::CH_BANG) begin
            ph_scan = xrts_pkg::PH_BANG;
          end else if (data_byte == xrts_pkg::CH_SLASH) begin
            ph_scan = xrts_pkg::PH_NOROOT;
          end else if (xrts_pkg::is_term(data_byte)) begin
            ph_scan = xrts_pkg::PH_EMPTY;
          end else begin
            ph_scan = xrts_pkg::PH_NAME;
            take    = 1'b1;
          end
        end
        xrts_pkg::PH_BANG: begin
          ph_scan = (data_byte == xrts_pkg::CH_DASH) ? xrts_pkg::PH_BANG_DASH
                                                     : xrts_pkg::PH_DECL;
        end
        xrts_pkg::PH_BANG_DASH: begin
          if (data_byte == xrts_pkg::CH_DASH) begin
            ph_scan = xrts_pkg::PH_COMMENT;
            cp_scan = 2'd0;
          end else begin
            ph_scan = xrts_pkg::PH_DECL;
          end
        end
        xrts_pkg::PH_PI: begin
          if (data_byte == xrts_pkg::CH_GT && cp_base == 2'd1) begin
            ph_scan = xrts_pkg::PH_WS;
            cp_scan = 2'd0;
          end else begin
            cp_scan = (data_byte == xrts_pkg::CH_QUEST) ? 2'd1 : 2'd0;
          end
        end
        xrts_pkg::PH_COMMENT: begin
          if (data_byte == xrts_pkg::CH_GT && cp_base >= 2'd2) begin
            ph_scan = xrts_pkg::PH_WS;
            cp_scan = 2'd0;
          end else if (data_byte == xrts_pkg::CH_DASH) begin
            cp_scan = (cp_base >= 2'd2) ? 2'd2 : cp_base + 2'd1;
          end else begin
            cp_scan = 2'd0;
          end
        end
        xrts_pkg::PH_NAME: begin
          if (xrts_pkg::is_term(data_byte)) ph_scan = xrts_pkg::PH_DONE;
          else take = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign sel = len_base[3:0];

  // Capture: append the byte, compare it against the effective tag.
  always_comb begin
    len_base  = first_of_file ? '0 : cap_len;
    diff_base = first_of_file ? 1'b0 : differs;
    len_scan  = len_base;
    diff_scan = diff_base;
    wr        = '0;
    if (in_fire && take) begin
      if (len_base < LW'(NameCap)) begin
        wr.en    = 1'b1;
        wr.addr  = len_base[3:0];
        wr.value = data_byte;
        if (len_base >= view.eff_len || view.ref_byte != data_byte) begin
          diff_scan = 1'b1;
        end
        len_scan = len_base + LW'(1);
      end else begin
        len_scan = LW'(NameCap + 1);
      end
    end
  end

  // Result of a file that ends on this item.
  always_comb begin
    res_status  = xrts_pkg::ST_NO_ROOT;
    res_learned = 1'b0;
    n_rep       = '0;
    learn       = 1'b0;
    show_name   = 1'b0;
    unique case (ph_scan) inside
      xrts_pkg::PH_WS, xrts_pkg::PH_NOROOT: res_status = xrts_pkg::ST_NO_ROOT;
      xrts_pkg::PH_LT, xrts_pkg::PH_EMPTY:  res_status = xrts_pkg::ST_EMPTY;
      xrts_pkg::PH_BANG, xrts_pkg::PH_BANG_DASH, xrts_pkg::PH_DECL:
        res_status = xrts_pkg::ST_DECL;
      xrts_pkg::PH_PI:      res_status = xrts_pkg::ST_OPEN_PI;
      xrts_pkg::PH_COMMENT: res_status = xrts_pkg::ST_OPEN_CMT;
      xrts_pkg::PH_NAME, xrts_pkg::PH_DONE: begin
        show_name = 1'b1;
        res_status = xrts_pkg::ST_OK;
        n_rep = len_scan;
        if (len_scan > LW'(NameCap)) begin
          res_status = xrts_pkg::ST_TOO_LONG;
          n_rep = LW'(NameCap);
        end else if (view.eff_len == '0) begin
          learn = 1'b1;
          res_learned = 1'b1;
        end else if (diff_scan || len_scan != view.eff_len) begin
          res_status = xrts_pkg::ST_MISMATCH;
        end
      end
      default: res_status = xrts_pkg::ST_NO_ROOT;
    endcase
  end

  for (genvar k = 0; k < xrts_pkg::TAG_BYTES; k++) begin : g_bytes
    if (k < NameCap) begin : g_live
      logic [7:0] now_byte;
      // Bypass the byte written on this same item.
      assign now_byte = (wr.en && wr.addr == 4'(k)) ? data_byte : cap_name[k];
      assign bytes_out[k] = (show_name && LW'(k) < n_rep) ? now_byte : 8'd0;
    end else begin : g_dead
      assign bytes_out[k] = 8'd0;
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      name_lo[8*k +: 8] = bytes_out[k];
      name_hi[8*k +: 8] = bytes_out[k+8];
    end
  end

  assign res = '{res_status, n_rep, name_lo, name_hi, res_learned};

  assign res_valid     = in_fire && last_of_file;
  assign commit.en     = res_valid && learn;
  assign commit.length = n_rep;

  // Memory read address follows the index the next item will use.
  assign len_d = !in_fire ? cap_len : (last_of_file ? '0 : len_scan);
  assign raddr = (len_d < LW'(NameCap)) ? len_d[3:0] : 4'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= xrts_pkg::PH_WS;
      cp      <= 2'd0;
      cap_len <= '0;
      differs <= 1'b0;
    end else if (in_fire) begin
      if (last_of_file) begin
        phase   <= xrts_pkg::PH_WS;
        cp      <= 2'd0;
        cap_len <= '0;
        differs <= 1'b0;
      end else begin
        phase   <= ph_scan;
        cp      <= cp_scan;
        cap_len <= len_scan;
        differs <= diff_scan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      cap_name[wr.addr[IdxW-1:0]] <= data_byte;
    end
  end

endmodule

// ===== rtl/xrts_out_fifo.sv =====
// Two-entry result queue that decouples the scanner from the result receiver.
// Depends on xrts_pkg and xrts_out_if.
`timescale 1ns / 1ps

module xrts_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xrts_pkg::result_t din,
  output logic              full,
  xrts_out_if.source        dout
);

  xrts_pkg::result_t slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              pop;

  assign full = (count == 2'd2);
  assign pop  = dout.valid && dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  assign dout.valid       = (count != 2'd0);
  assign dout.status      = slots[rd_ptr].status;
  assign dout.name_length = slots[rd_ptr].name_length;
  assign dout.name_low    = slots[rd_ptr].name_low;
  assign dout.name_high   = slots[rd_ptr].name_high;
  assign dout.tag_learned = slots[rd_ptr].tag_learned;

endmodule

// ===== rtl/xml_root_tag_scanner_unit.sv =====
// Top level of the XML root tag scanner.
// Depends on xrts_pkg, xrts_if, xrts_tag_store, xrts_scan_core, xrts_out_fifo.
`timescale 1ns / 1ps

// Usage:
//   item_in  - one file byte per transfer, with has_byte, first_of_file and
//              last_of_file marks. One transfer per cycle is sustained while item_in.ready is high.
//   item_out - one result per file, produced by the transfer that carries
//              last_of_file; it is written into the result queue and leaves it in order.
//   cfg      - register writes (expected tag low/high/length), always ready;
//              write only while no file is in flight.
// Throughput is one byte per cycle while the result queue has room: each byte
// does one state step and one name-byte compare, the compare byte coming from
// the learned-tag memory, a registered read addressed ahead at the next name index.
// Results go through a two-entry queue, so input keeps flowing while one
// result waits. If the receiver stalls long enough to fill the queue,
// item_in.ready drops until a result transfer frees a slot.
// Reset (rst, synchronous) clears the scan, the expected tag and the
// learned tag; no clearing pass is needed.
module xml_root_tag_scanner_unit #(
  parameter int MAX_NAME_BYTES = xrts_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  xrts_in_if.sink     item_in,
  xrts_out_if.source  item_out,
  xrts_cfg_if.sink    cfg
);

  xrts_pkg::tag_wr_t     wr;
  xrts_pkg::tag_commit_t commit;
  xrts_pkg::tag_view_t   view;
  xrts_pkg::result_t     res;
  logic [3:0]            raddr;
  logic [3:0]            sel;
  logic                  res_valid;
  logic                  fifo_full;
  logic                  in_fire;

  assign item_in.ready = !fifo_full;
  assign in_fire       = item_in.valid && item_in.ready;

  xrts_tag_store u_tag_store (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .wr     (wr),
    .commit (commit),
    .raddr  (raddr),
    .sel    (sel),
    .view   (view)
  );

  xrts_scan_core #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_scan_core (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .data_byte     (item_in.data_byte),
    .has_byte      (item_in.has_byte),
    .first_of_file (item_in.first_of_file),
    .last_of_file  (item_in.last_of_file),
    .view          (view),
    .wr            (wr),
    .commit        (commit),
    .raddr         (raddr),
    .sel           (sel),
    .res_valid     (res_valid),
    .res           (res)
  );

  xrts_out_fifo u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (res_valid),
    .din  (res),
    .full (fifo_full),
    .dout (item_out)
  );

endmodule

// ===== dv/xml_root_tag_scanner_unit_test.sv =====
// Self-checking testbench for xml_root_tag_scanner_unit: file streams, tag registers, results.
// Depends on xrts_pkg, the xrts_*_if interfaces and the scanner top level.
`timescale 1ns / 1ps

module xml_root_tag_scanner_unit_test;

  localparam int MAX_NAME     = xrts_pkg::MAX_NAME_BYTES_DEF;
  localparam int NAME_CAP     = (MAX_NAME < 16) ? MAX_NAME : 16;
  localparam int PHASE_BYTES  = 75;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {GAP_NONE, GAP_FULL, GAP_SPARSE} gap_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       first;
    logic       last;
  } scan_item_t;

  typedef logic [7:0] byte_q [$];
  typedef scan_item_t item_q [$];

  typedef struct {
    string             text;
    int                restart_at;
    bit                no_first;
    bit                hole;
    bit                pin;
    xrts_pkg::status_t want;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;

  xrts_in_if  in_if ();
  xrts_out_if out_if ();
  xrts_cfg_if cfg_if ();

  xml_root_tag_scanner_unit #(.MAX_NAME_BYTES(MAX_NAME)) dut (
    .clk     (clk),
    .rst     (rst),
    .item_in (in_if),
    .item_out(out_if),
    .cfg     (cfg_if)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Pinned expectation travels with the last item of a directed file.
  logic              in_pin = 1'b0;
  xrts_pkg::status_t in_pin_st = xrts_pkg::ST_OK;

  gap_mode_t         src_mode = GAP_FULL;
  int                hold_req = 0;
  int                errors = 0;
  int unsigned       cycle_count = 0;
  xrts_pkg::result_t want_q [$];
  dir_row_t          dir_rows [$];

  logic [7:0] stops [7] = '{8'h20, 8'h09, 8'h0D, 8'h0A, xrts_pkg::CH_SLASH, xrts_pkg::CH_GT,
                            xrts_pkg::CH_EQ};

  // Scanner model state and tag registers.
  xrts_pkg::phase_t scan_ph;
  logic [1:0]       closer;
  logic [4:0]       cap_len;
  logic [7:0]       cap_name [16];
  logic [7:0]       lrn_name [16];
  logic [4:0]       lrn_len;
  bit               differs;
  logic [63:0]      tag_lo;
  logic [63:0]      tag_hi;
  logic [4:0]       tag_len;

  function automatic bit blank_byte(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction

  function automatic bit name_stop(input logic [7:0] b);
    return blank_byte(b) || b == xrts_pkg::CH_SLASH || b == xrts_pkg::CH_GT ||
           b == xrts_pkg::CH_EQ;
  endfunction

  function automatic int tag_len_now();
    if (tag_len != 0) return (tag_len > 16) ? 16 : tag_len;
    return lrn_len;
  endfunction

  function automatic logic [7:0] tag_byte_at(input int i);
    if (tag_len != 0) return (i < 8) ? tag_lo[8*i +: 8] : tag_hi[8*(i-8) +: 8];
    return lrn_name[i];
  endfunction

  task automatic rewind_scan();
    scan_ph = xrts_pkg::PH_WS;
    closer  = 2'd0;
    cap_len = 5'd0;
    differs = 1'b0;
  endtask

  task automatic take_name_byte(input logic [7:0] b);
    if (cap_len < NAME_CAP) begin
      cap_name[cap_len[3:0]] = b;
      if (cap_len >= tag_len_now() || tag_byte_at(cap_len) != b) differs = 1'b1;
      cap_len = cap_len + 5'd1;
    end else begin
      cap_len = 5'(NAME_CAP + 1);
    end
  endtask

  task automatic scan_byte(input logic [7:0] b);
    case (scan_ph)
      xrts_pkg::PH_WS: begin
        if (b == xrts_pkg::CH_LT) scan_ph = xrts_pkg::PH_LT;
        else if (!blank_byte(b)) scan_ph = xrts_pkg::PH_NOROOT;
      end
      xrts_pkg::PH_LT: begin
        if (b == xrts_pkg::CH_QUEST) begin
          scan_ph = xrts_pkg::PH_PI;
          closer  = 2'd0;
        end else if (b == xrts_pkg::CH_BANG) begin
          scan_ph = xrts_pkg::PH_BANG;
        end else if (b == xrts_pkg::CH_SLASH) begin
          scan_ph = xrts_pkg::PH_NOROOT;
        end else if (name_stop(b)) begin
          scan_ph = xrts_pkg::PH_EMPTY;
        end else begin
          scan_ph = xrts_pkg::PH_NAME;
          take_name_byte(b);
        end
      end
      xrts_pkg::PH_BANG: begin
        scan_ph = (b == xrts_pkg::CH_DASH) ? xrts_pkg::PH_BANG_DASH : xrts_pkg::PH_DECL;
      end
      xrts_pkg::PH_BANG_DASH: begin
        if (b == xrts_pkg::CH_DASH) begin
          scan_ph = xrts_pkg::PH_COMMENT;
          closer  = 2'd0;
        end else begin
          scan_ph = xrts_pkg::PH_DECL;
        end
      end
      xrts_pkg::PH_PI: begin
        if (b == xrts_pkg::CH_GT && closer == 2'd1) begin
          scan_ph = xrts_pkg::PH_WS;
          closer  = 2'd0;
        end else begin
          closer = (b == xrts_pkg::CH_QUEST) ? 2'd1 : 2'd0;
        end
      end
      xrts_pkg::PH_COMMENT: begin
        if (b == xrts_pkg::CH_GT && closer >= 2'd2) begin
          scan_ph = xrts_pkg::PH_WS;
          closer  = 2'd0;
        end else if (b == xrts_pkg::CH_DASH) begin
          closer = (closer >= 2'd2) ? 2'd2 : closer + 2'd1;
        end else begin
          closer = 2'd0;
        end
      end
      xrts_pkg::PH_NAME: begin
        if (name_stop(b)) scan_ph = xrts_pkg::PH_DONE;
        else take_name_byte(b);
      end
      default: ;
    endcase
  endtask

  task automatic close_file(output xrts_pkg::result_t r);
    int n;
    int el;
    int i;
    r = '0;
    case (scan_ph) inside
      xrts_pkg::PH_WS, xrts_pkg::PH_NOROOT: r.status = xrts_pkg::ST_NO_ROOT;
      xrts_pkg::PH_LT, xrts_pkg::PH_EMPTY:  r.status = xrts_pkg::ST_EMPTY;
      xrts_pkg::PH_BANG, xrts_pkg::PH_BANG_DASH, xrts_pkg::PH_DECL:
        r.status = xrts_pkg::ST_DECL;
      xrts_pkg::PH_PI:      r.status = xrts_pkg::ST_OPEN_PI;
      xrts_pkg::PH_COMMENT: r.status = xrts_pkg::ST_OPEN_CMT;
      xrts_pkg::PH_NAME, xrts_pkg::PH_DONE: begin
        n = cap_len;
        if (n > NAME_CAP) begin
          r.status = xrts_pkg::ST_TOO_LONG;
          n = NAME_CAP;
        end else begin
          el = tag_len_now();
          r.status = xrts_pkg::ST_OK;
          if (el == 0) begin
            for (i = 0; i < 16; i++) lrn_name[i] = cap_name[i];
            lrn_len = 5'(n);
            r.tag_learned = 1'b1;
          end else if (differs || n != el) begin
            r.status = xrts_pkg::ST_MISMATCH;
          end
        end
        r.name_length = 5'(n);
        for (i = 0; i < n; i++) begin
          if (i < 8) r.name_low[8*i +: 8] = cap_name[i];
          else r.name_high[8*(i-8) +: 8] = cap_name[i];
        end
      end
      default: r.status = xrts_pkg::ST_NO_ROOT;
    endcase
  endtask

  task automatic predict_item(input scan_item_t it, output bit fired,
                              output xrts_pkg::result_t r);
    fired = 1'b0;
    r = '0;
    if (it.first) rewind_scan();
    if (it.has) scan_byte(it.data);
    if (it.last) begin
      close_file(r);
      rewind_scan();
      fired = 1'b1;
    end
  endtask

  task automatic check_result(input xrts_pkg::result_t w);
    if (out_if.status !== w.status) begin
      $error("status: expected %0d, got %0d", w.status, out_if.status);
      errors++;
    end
    if (out_if.name_length !== w.name_length) begin
      $error("name_length: expected %0d, got %0d", w.name_length, out_if.name_length);
      errors++;
    end
    if (out_if.name_low !== w.name_low) begin
      $error("name_low: expected %h, got %h", w.name_low, out_if.name_low);
      errors++;
    end
    if (out_if.name_high !== w.name_high) begin
      $error("name_high: expected %h, got %h", w.name_high, out_if.name_high);
      errors++;
    end
    if (out_if.tag_learned !== w.tag_learned) begin
      $error("tag_learned: expected %0d, got %0d", w.tag_learned, out_if.tag_learned);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    xrts_pkg::result_t r;
    bit                fired;
    scan_item_t        it;
    if (!rst) begin
      if (out_if.valid && out_if.ready) begin
        if (want_q.size() == 0) begin
          $error("result transfer with nothing expected: status %0d", out_if.status);
          errors++;
        end else begin
          check_result(want_q.pop_front());
        end
      end
      if (in_if.valid && in_if.ready) begin
        it = '{in_if.data_byte, in_if.has_byte, in_if.first_of_file, in_if.last_of_file};
        predict_item(it, fired, r);
        if (fired) begin
          if (in_pin) begin
            r = '0;
            r.status = in_pin_st;
          end
          want_q = {want_q, r};
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          xrts_pkg::CFG_TAG_LOW:    tag_lo = cfg_if.data;
          xrts_pkg::CFG_TAG_HIGH:   tag_hi = cfg_if.data;
          xrts_pkg::CFG_TAG_LENGTH: tag_len = cfg_if.data[4:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("xml_root_tag_scanner_unit_test failed");
      $finish;
    end
  end

  function automatic int draw_gap(input gap_mode_t mode);
    case (mode)
      GAP_NONE: return 0;
      GAP_FULL: return $urandom_range(0, 14);
      default:  return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
    endcase
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : sink_side
    int        stall;
    gap_mode_t mode;
    out_if.ready = 1'b0;
    mode = GAP_FULL;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) mode = gap_mode_t'($urandom_range(0, 2));
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = draw_gap(mode);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  task automatic drive_item(input scan_item_t it, input bit pin, input xrts_pkg::status_t st);
    int gap;
    gap = draw_gap(src_mode);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= it.data;
    in_if.has_byte      <= it.has;
    in_if.first_of_file <= it.first;
    in_if.last_of_file  <= it.last;
    in_pin              <= pin;
    in_pin_st           <= st;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_file(input item_q items, input bit pin, input xrts_pkg::status_t st);
    foreach (items[i]) drive_item(items[i], pin && items[i].last, st);
  endtask

  // Drop valid and hold until every result is back, then idle for the requested extra cycles.
  task automatic settle(input int extra);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_apply(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [4:0] len);
    logic [63:0]        vals [3];
    xrts_pkg::cfg_reg_t regs [3];
    int                 s;
    int                 k;
    vals = '{lo, hi, {59'd0, len}};
    regs = '{xrts_pkg::CFG_TAG_LOW, xrts_pkg::CFG_TAG_HIGH, xrts_pkg::CFG_TAG_LENGTH};
    s = $urandom_range(0, 2);
    for (k = 0; k < 3; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[(s + k) % 3];
      cfg_if.data  <= vals[(s + k) % 3];
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 1) return 8'h61 + 8'($urandom_range(0, 25));
    do b = 8'($urandom_range(0, 255)); while (name_stop(b));
    return b;
  endfunction

  function automatic void build_tag(input int n, output logic [63:0] lo,
                                    output logic [63:0] hi);
    logic [7:0] b;
    int         i;
    for (i = 0; i < 16; i++) begin
      b = (i < n) ? name_byte() : 8'($urandom_range(0, 255));
      if (i < 8) lo[8*i +: 8] = b;
      else hi[8*(i-8) +: 8] = b;
    end
  endfunction

  function automatic void add_text(ref byte_q q, input string s);
    for (int i = 0; i < s.len(); i++) q = {q, 8'(s[i])};
  endfunction

  // Markup body with no '>' so a PI or comment cannot close early.
  function automatic void add_filler(ref byte_q q, input int n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       b = xrts_pkg::CH_QUEST;
        1:       b = xrts_pkg::CH_DASH;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (b == xrts_pkg::CH_GT) b = xrts_pkg::CH_DASH;
      q = {q, b};
    end
  endfunction

  function automatic byte_q pick_name();
    byte_q nm;
    int    el;
    int    r;
    int    i;
    el = tag_len_now();
    r = $urandom_range(0, 99);
    if (el != 0 && r < 60) begin
      for (i = 0; i < el; i++) nm = {nm, tag_byte_at(i)};
      if (r >= 45) begin
        case ($urandom_range(0, 2))
          0: nm[$urandom_range(0, el - 1)] = name_byte();
          1: if (el > 1) void'(nm.pop_back());
          default: nm = {nm, name_byte()};
        endcase
      end
    end else if (r < 68) begin
      repeat (NAME_CAP + $urandom_range(1, 3)) nm = {nm, name_byte()};
    end else begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, NAME_CAP) : $urandom_range(1, 6))
        nm = {nm, name_byte()};
    end
    return nm;
  endfunction

  function automatic void make_file(output byte_q q, output int restart_at,
                                    output bit no_first, output bit hole);
    q = {};
    restart_at = -1;
    no_first = ($urandom_range(0, 19) == 0);
    hole = ($urandom_range(0, 15) == 0);
    if ($urandom_range(0, 99) < 75) begin
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 2))
          0: repeat ($urandom_range(1, 3)) q = {q, stops[$urandom_range(0, 3)]};
          1: begin
            add_text(q, "<?");
            add_filler(q, $urandom_range(0, 5));
            add_text(q, "?>");
          end
          default: begin
            add_text(q, "<!--");
            add_filler(q, $urandom_range(0, 5));
            add_text(q, "-->");
          end
        endcase
      end
      q = {q, xrts_pkg::CH_LT};
      q = {q, pick_name()};
      if ($urandom_range(0, 9) != 0) begin
        q = {q, stops[$urandom_range(0, 6)]};
        repeat ($urandom_range(0, 3)) q = {q, 8'($urandom_range(0, 255))};
      end
    end else begin
      case ($urandom_range(0, 5))
        0: repeat ($urandom_range(0, 6)) q = {q, 8'($urandom_range(0, 255))};
        1: begin
          add_text(q, "<!");
          if ($urandom_range(0, 1) == 1) q = {q, xrts_pkg::CH_DASH};
          repeat ($urandom_range(0, 3)) q = {q, 8'($urandom_range(0, 255))};
        end
        2: begin
          add_text(q, "<?");
          add_filler(q, $urandom_range(0, 6));
        end
        3: begin
          add_text(q, "<!--");
          add_filler(q, $urandom_range(0, 6));
        end
        4: begin
          q = {q, xrts_pkg::CH_LT};
          if ($urandom_range(0, 3) != 0) q = {q, stops[$urandom_range(0, 6)]};
          repeat ($urandom_range(0, 2)) q = {q, 8'($urandom_range(0, 255))};
        end
        default: begin
          // Partial file, then a fresh first mark mid-stream.
          q = {q, xrts_pkg::CH_LT};
          repeat ($urandom_range(1, 5)) q = {q, name_byte()};
          restart_at = q.size();
          q = {q, xrts_pkg::CH_LT};
          q = {q, pick_name()};
          q = {q, xrts_pkg::CH_GT};
        end
      endcase
    end
  endfunction

  function automatic void frame_file(input byte_q body, input int restart_at,
                                     input bit no_first, input bit hole,
                                     output item_q items);
    scan_item_t it;
    items = {};
    for (int i = 0; i < body.size(); i++) begin
      it.data  = body[i];
      it.has   = 1'b1;
      it.first = (i == 0 && !no_first) || i == restart_at;
      it.last  = 1'b0;
      items = {items, it};
    end
    if (hole || items.size() == 0) begin
      it.data  = 8'($urandom_range(0, 255));
      it.has   = 1'b0;
      it.first = (items.size() == 0) && !no_first;
      it.last  = 1'b0;
      items.insert($urandom_range(0, items.size()), it);
    end
    items[items.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_row(input string text, input int restart_at, input bit no_first,
                                  input bit hole, input bit pin, input xrts_pkg::status_t want);
    dir_row_t r;
    r.text = text;
    r.restart_at = restart_at;
    r.no_first = no_first;
    r.hole = hole;
    r.pin = pin;
    r.want = want;
    dir_rows = {dir_rows, r};
  endfunction

  initial begin : stimulus
    byte_q       body;
    item_q       items;
    int          restart_at;
    bit          no_first;
    bit          hole;
    int          sent;
    int          n;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;

    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.has_byte = 1'b0;
    in_if.first_of_file = 1'b0;
    in_if.last_of_file = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = xrts_pkg::CFG_TAG_LOW;
    cfg_if.data = 64'd0;

    tag_lo = '0;
    tag_hi = '0;
    tag_len = '0;
    lrn_len = '0;
    for (int i = 0; i < 16; i++) begin
      cap_name[i] = 8'h00;
      lrn_name[i] = 8'h00;
    end
    rewind_scan();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    //       text                        restart no_first hole pin  status
    add_row("",                         -1, 0, 0, 1, xrts_pkg::ST_NO_ROOT);
    add_row(" \t\015\n",                -1, 0, 0, 1, xrts_pkg::ST_NO_ROOT);
    add_row("x<a>",                     -1, 0, 0, 1, xrts_pkg::ST_NO_ROOT);
    add_row("</a>",                     -1, 0, 0, 1, xrts_pkg::ST_NO_ROOT);
    add_row("<",                        -1, 0, 0, 1, xrts_pkg::ST_EMPTY);
    add_row("<>",                       -1, 0, 0, 1, xrts_pkg::ST_EMPTY);
    add_row("< a",                      -1, 0, 0, 1, xrts_pkg::ST_EMPTY);
    add_row("<!",                       -1, 0, 0, 1, xrts_pkg::ST_DECL);
    add_row("<!-",                      -1, 0, 0, 1, xrts_pkg::ST_DECL);
    add_row("<!DOCTYPE r>",             -1, 0, 0, 1, xrts_pkg::ST_DECL);
    add_row("<?>",                      -1, 0, 0, 1, xrts_pkg::ST_OPEN_PI);
    add_row("<!-->",                    -1, 0, 0, 1, xrts_pkg::ST_OPEN_CMT);
    add_row("<?pi ??><!-- a - -- b --><!---->\n<root a=\"1\">",
            -1, 0, 0, 0, xrts_pkg::ST_OK);
    add_row("<root/>",                  -1, 0, 0, 0, xrts_pkg::ST_OK);
    add_row("<roo>",                    -1, 0, 0, 0, xrts_pkg::ST_OK);
    add_row("<roots",                   -1, 0, 0, 0, xrts_pkg::ST_OK);
    add_row("<abcdefghijklmnopq>",      -1, 0, 0, 0, xrts_pkg::ST_OK);
    add_row("<abcdefghijklmnop>",       -1, 0, 0, 0, xrts_pkg::ST_OK);
    add_row("<\377\200=",               -1, 0, 0, 0, xrts_pkg::ST_OK);
    add_row("<zz<root>",                 3, 0, 0, 0, xrts_pkg::ST_OK);
    add_row("\t<root\n>",               -1, 1, 1, 0, xrts_pkg::ST_OK);

    foreach (dir_rows[k]) begin
      body = {};
      add_text(body, dir_rows[k].text);
      frame_file(body, dir_rows[k].restart_at, dir_rows[k].no_first, dir_rows[k].hole, items);
      send_file(items, dir_rows[k].pin, dir_rows[k].want);
    end

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin lo = '1; hi = '1; len = 5'd16; end
        1: begin lo = '0; hi = '0; len = 5'd31; end
        2: begin build_tag(1, lo, hi); len = 5'd1; end
        3: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; len = 5'd0; end
        4: begin n = $urandom_range(2, 15); build_tag(n, lo, hi); len = 5'(n); end
        5: begin build_tag(16, lo, hi); len = 5'($urandom_range(17, 30)); end
        default: begin lo = {$urandom, $urandom}; hi = ~lo; len = 5'd0; end
      endcase
      settle(DRAIN_CYCLES);
      cfg_apply(lo, hi, len);

      if (p == 3) begin
        // Stall the result side and flood short files so the input backs up.
        hold_req = HOLD_CYCLES;
        src_mode = GAP_NONE;
        repeat (30) begin
          body = {};
          body = {body, xrts_pkg::CH_LT};
          body = {body, pick_name()};
          body = {body, xrts_pkg::CH_GT};
          frame_file(body, -1, 0, 0, items);
          send_file(items, 0, xrts_pkg::ST_OK);
        end
        settle(0);
      end

      sent = 0;
      while (sent < PHASE_BYTES) begin
        if ($urandom_range(0, 11) == 0) src_mode = gap_mode_t'($urandom_range(0, 2));
        make_file(body, restart_at, no_first, hole);
        frame_file(body, restart_at, no_first, hole, items);
        send_file(items, 0, xrts_pkg::ST_OK);
        sent += items.size();
        if ($urandom_range(0, 29) == 0) settle(0);
      end
    end

    settle(DRAIN_CYCLES);
    if (errors == 0) begin
      $display("xml_root_tag_scanner_unit_test passed");
    end else begin
      $display("xml_root_tag_scanner_unit_test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/xrts_pkg.sv
rtl/xrts_if.sv
rtl/xrts_tag_store.sv
rtl/xrts_scan_core.sv
rtl/xrts_out_fifo.sv
rtl/xml_root_tag_scanner_unit.sv
dv/xml_root_tag_scanner_unit_test.sv
